// File: hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    // Parser phase. Codes 6 and 7 are unused and parse as BYTE0.
    typedef enum logic [2:0] {
        PH_BYTE0   = 3'd0,
        PH_BYTE1   = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    localparam int unsigned LEN_W = 64;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned CNT_W = 3;

    localparam logic [6:0]       LEN7_EXT16 = 7'd126;
    localparam logic [6:0]       LEN7_EXT64 = 7'd127;
    localparam logic [CNT_W-1:0] EXT16_LAST = 3'd1;
    localparam logic [CNT_W-1:0] EXT64_LAST = 3'd7;
    localparam logic [CNT_W-1:0] KEY_LAST   = 3'd3;

    // One result word.
    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             frame_fin;
        logic [3:0]       frame_kind;
        logic             frame_was_masked;
        logic [LEN_W-1:0] frame_length;
        logic             empty_frame;
        logic             last_of_frame;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/wsd_in_stage.sv
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // full and not drained this cycle
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: hdl/wsd_parse_core.sv
// ----------------------------------------------------------------------------
// wsd_parse_core
// Frame header state machine and payload unmasking, one byte per cycle while i_fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parse_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_byte,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);

    wsd_pkg::t_phase              r_phase,  n_phase;
    logic                         r_fin,    n_fin;
    logic [3:0]                   r_opcode, n_opcode;
    logic                         r_mask,   n_mask;
    logic [wsd_pkg::LEN_W-1:0]    r_length, n_length;
    logic [wsd_pkg::CNT_W-1:0]    r_hcount, n_hcount;
    logic [wsd_pkg::KEY_W-1:0]    r_key,    n_key;
    logic [wsd_pkg::LEN_W-1:0]    r_index,  n_index;

    logic                         len_done;
    logic                         hdr_done;
    logic                         res_valid;
    logic                         res_empty;
    logic                         res_last;
    logic [7:0]                   res_data;
    logic [7:0]                   key_byte;
    logic [6:0]                   len7;
    logic                         pay_last;
    logic [wsd_pkg::CNT_W-1:0]    ext_last;

    assign len7     = i_byte[6:0];
    assign pay_last = ((r_index + 64'd1) == r_length);
    assign ext_last = (r_phase == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                     : wsd_pkg::EXT64_LAST;

    // key byte 0 sits in the top bits
    always_comb begin
        case (r_index[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_mask    = r_mask;
        n_length  = r_length;
        n_hcount  = r_hcount;
        n_key     = r_key;
        n_index   = r_index;
        len_done  = 1'b0;
        hdr_done  = 1'b0;
        res_valid = 1'b0;
        res_empty = 1'b0;
        res_last  = 1'b0;
        res_data  = 8'd0;

        unique case (r_phase) inside
            wsd_pkg::PH_BYTE1: begin
                n_mask   = i_byte[7];
                n_hcount = '0;
                if (len7 == wsd_pkg::LEN7_EXT16) begin
                    n_length = '0;
                    n_phase  = wsd_pkg::PH_EXT16;
                end else if (len7 == wsd_pkg::LEN7_EXT64) begin
                    n_length = '0;
                    n_phase  = wsd_pkg::PH_EXT64;
                end else begin
                    n_length = {57'd0, len7};
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
                n_length = {r_length[55:0], i_byte};
                if (r_hcount >= ext_last) begin
                    n_hcount = '0;
                    len_done = 1'b1;
                end else begin
                    n_hcount = r_hcount + 3'd1;
                end
            end
            wsd_pkg::PH_KEY: begin
                n_key = {r_key[23:0], i_byte};
                if (r_hcount >= wsd_pkg::KEY_LAST) begin
                    n_hcount = '0;
                    hdr_done = 1'b1;
                end else begin
                    n_hcount = r_hcount + 3'd1;
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                res_valid = 1'b1;
                res_data  = r_mask ? (i_byte ^ key_byte) : i_byte;
                res_last  = pay_last;
                if (pay_last) begin
                    n_phase = wsd_pkg::PH_BYTE0;
                    n_index = '0;
                end else begin
                    n_index = r_index + 64'd1;
                end
            end
            default: begin
                n_fin    = i_byte[7];
                n_opcode = i_byte[3:0];
                n_phase  = wsd_pkg::PH_BYTE1;
            end
        endcase

        // length known: read key if masked, else header is complete
        if (len_done) begin
            n_key = '0;
            if (n_mask) begin
                n_phase  = wsd_pkg::PH_KEY;
                n_hcount = '0;
            end else begin
                hdr_done = 1'b1;
            end
        end

        // header complete: zero length gives one empty marker
        if (hdr_done) begin
            n_index = '0;
            if (n_length == '0) begin
                res_valid = 1'b1;
                res_empty = 1'b1;
                res_last  = 1'b1;
                n_phase   = wsd_pkg::PH_BYTE0;
            end else begin
                n_phase   = wsd_pkg::PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_BYTE0;
            r_fin    <= 1'b0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_length <= '0;
            r_hcount <= '0;
            r_key    <= '0;
            r_index  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_length <= n_length;
            r_hcount <= n_hcount;
            r_key    <= n_key;
            r_index  <= n_index;
        end
    end

    assign o_res_valid            = i_fire && res_valid;
    assign o_res.payload_byte     = res_data;
    assign o_res.frame_fin        = n_fin;
    assign o_res.frame_kind       = n_opcode;
    assign o_res.frame_was_masked = n_mask;
    assign o_res.frame_length     = n_length;
    assign o_res.empty_frame      = res_empty;
    assign o_res.last_of_frame    = res_last;

    // payload phase only with a nonzero length
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsd_pkg::PH_PAYLOAD) |-> (r_length != '0))
        else $error("payload phase with zero length");

    // data results only come from the payload phase
    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !res_empty) |-> (r_phase == wsd_pkg::PH_PAYLOAD))
        else $error("data result outside payload phase");

    // empty marker is last and carries zero length and data
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && res_empty) |->
            (res_last && (n_length == '0) && (res_data == 8'd0)))
        else $error("bad empty frame marker");

    // after the last result the parser waits for a new header
    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && res_last) |=> (r_phase == wsd_pkg::PH_BYTE0))
        else $error("parser did not return to header after last result");

endmodule

`default_nettype wire

// File: hdl/wsd_out_stage.sv
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register toward the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_valid,
    input  wire wsd_pkg::t_result i_res,
    output logic                  o_valid,
    output wsd_pkg::t_result      o_res
);

    logic             r_valid;
    wsd_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses an RFC 6455 frame byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
// Feed received bytes one word at a time on the input channel. Header bytes
// (opcode byte, length byte, 16- or 64-bit extended length, 4-byte masking
// key) produce no output; each payload byte produces one output word holding
// the unmasked byte plus FIN, opcode, mask flag and decoded length, with
// last_of_frame set on the frame's final byte. A zero-length frame produces a
// single word with empty_frame and last_of_frame set and a zero payload byte.
// Reserved bits are ignored and extended lengths are taken as received.
// Throughput is one byte per clock while the output is not stalled; an accepted
// byte passes through the input register, then the parser writes its result
// into the result register.
// Both channels use valid/stall; a stalled output holds the input register
// and, once that is full, stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // received byte stream
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    // parsed payload words
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_payload_byte,
    output logic             o_frame_fin,
    output logic [3:0]       o_frame_kind,
    output logic             o_frame_was_masked,
    output logic [63:0]      o_frame_length,
    output logic             o_empty_frame,
    output logic             o_last_of_frame
);

    logic             out_ready;   // result register can take a word
    logic             byte_valid;
    logic [7:0]       byte_data;
    logic             fire;        // parser consumes the held byte
    logic             res_valid;
    wsd_pkg::t_result res;
    wsd_pkg::t_result out_res;

    // The result register is free when empty or being drained. Every parse
    // step advances only then, so a header byte never races a held result.
    assign out_ready = !o_out_valid || !i_out_stall;
    assign fire      = byte_valid && out_ready;

    wsd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_in_byte),
        .i_take  (out_ready),
        .o_valid (byte_valid),
        .o_byte  (byte_data)
    );

    wsd_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (byte_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_ready),
        .i_valid (res_valid),
        .i_res   (res),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_payload_byte     = out_res.payload_byte;
    assign o_frame_fin        = out_res.frame_fin;
    assign o_frame_kind       = out_res.frame_kind;
    assign o_frame_was_masked = out_res.frame_was_masked;
    assign o_frame_length     = out_res.frame_length;
    assign o_empty_frame      = out_res.empty_frame;
    assign o_last_of_frame    = out_res.last_of_frame;

endmodule

`default_nettype wire

// File: test/ws_tracker_pkg.sv
// ----------------------------------------------------------------------------
// ws_tracker_pkg
// Scoreboard for the frame deframer: tracks the header and predicts each word.
// ----------------------------------------------------------------------------
package ws_tracker_pkg;

    class ws_payload_tracker;

        // parser state, kept in step with the block
        wsd_pkg::t_phase           phase;
        logic                      fin;
        logic [3:0]                kind;
        logic                      masked;
        logic [wsd_pkg::LEN_W-1:0] len;
        logic [wsd_pkg::CNT_W-1:0] cnt;
        logic [wsd_pkg::KEY_W-1:0] key;
        logic [wsd_pkg::LEN_W-1:0] idx;

        wsd_pkg::t_result due_words[$];
        int               mismatches;

        function new();
            phase      = wsd_pkg::PH_BYTE0;
            fin        = 1'b0;
            kind       = '0;
            masked     = 1'b0;
            len        = '0;
            cnt        = '0;
            key        = '0;
            idx        = '0;
            mismatches = 0;
        endfunction

        function void add_word(logic [7:0] data, logic empty, logic last);
            wsd_pkg::t_result w;
            w.payload_byte     = data;
            w.frame_fin        = fin;
            w.frame_kind       = kind;
            w.frame_was_masked = masked;
            w.frame_length     = len;
            w.empty_frame      = empty;
            w.last_of_frame    = last;
            due_words.insert(due_words.size(), w);
        endfunction

        // length and key are complete
        function void header_complete();
            idx = '0;
            if (len == '0) begin
                add_word(8'h00, 1'b1, 1'b1);
                phase = wsd_pkg::PH_BYTE0;
            end else begin
                phase = wsd_pkg::PH_PAYLOAD;
            end
        endfunction

        // length known; a masked frame still reads its key
        function void length_complete();
            key = '0;
            if (masked) begin
                phase = wsd_pkg::PH_KEY;
                cnt   = '0;
            end else begin
                header_complete();
            end
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0]                data;
            logic                      last;
            logic [wsd_pkg::CNT_W-1:0] ext_last;
            case (phase) inside
                wsd_pkg::PH_BYTE1: begin
                    masked = b[7];
                    cnt    = '0;
                    if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
                        len   = '0;
                        phase = wsd_pkg::PH_EXT16;
                    end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
                        len   = '0;
                        phase = wsd_pkg::PH_EXT64;
                    end else begin
                        len = wsd_pkg::LEN_W'(b[6:0]);
                        length_complete();
                    end
                end
                wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
                    len = {len[wsd_pkg::LEN_W-9:0], b};
                    ext_last = (phase == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                            : wsd_pkg::EXT64_LAST;
                    if (cnt >= ext_last) begin
                        cnt = '0;
                        length_complete();
                    end else begin
                        cnt = cnt + 1'b1;
                    end
                end
                wsd_pkg::PH_KEY: begin
                    key = {key[wsd_pkg::KEY_W-9:0], b};
                    if (cnt >= wsd_pkg::KEY_LAST) begin
                        cnt = '0;
                        header_complete();
                    end else begin
                        cnt = cnt + 1'b1;
                    end
                end
                wsd_pkg::PH_PAYLOAD: begin
                    data = b;
                    if (masked)
                        data = data ^ key[8*(3 - idx[1:0]) +: 8];
                    last = (idx == len - 1'b1);
                    add_word(data, 1'b0, last);
                    if (last) begin
                        phase = wsd_pkg::PH_BYTE0;
                        idx   = '0;
                    end else begin
                        idx = idx + 1'b1;
                    end
                end
                default: begin
                    fin   = b[7];
                    kind  = b[3:0];
                    phase = wsd_pkg::PH_BYTE1;
                end
            endcase
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                mismatches++;
                $error("%s: expected %0h, got %0h", field, want, seen);
            end
        endfunction

        function void match_word(wsd_pkg::t_result seen);
            wsd_pkg::t_result want;
            if (due_words.size() == 0) begin
                mismatches++;
                $error("unexpected output word, payload_byte %0h", seen.payload_byte);
            end else begin
                want = due_words.pop_front();
                compare_field("payload_byte", 64'(want.payload_byte),
                              64'(seen.payload_byte));
                compare_field("frame_fin", 64'(want.frame_fin), 64'(seen.frame_fin));
                compare_field("frame_kind", 64'(want.frame_kind), 64'(seen.frame_kind));
                compare_field("frame_was_masked", 64'(want.frame_was_masked),
                              64'(seen.frame_was_masked));
                compare_field("frame_length", want.frame_length, seen.frame_length);
                compare_field("empty_frame", 64'(want.empty_frame),
                              64'(seen.empty_frame));
                compare_field("last_of_frame", 64'(want.last_of_frame),
                              64'(seen.last_of_frame));
            end
        endfunction

    endclass

endpackage

// File: test/tb_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Feeds WebSocket frame streams into the deframer and checks every payload word.
// ----------------------------------------------------------------------------
// A directed run covers empty frames (plain and masked), reserved bits, both
// extended-length forms coded long and the byte extremes. Random frames then
// follow with mixed length coding, masking and sizes, under three idle/stall
// mixes. The run ends with a 64-bit length whose top bit is set; that frame
// never completes, so only part of its payload is sent.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {LEN_SHORT, LEN_16, LEN_64} t_len_code;

    localparam int ITEMS       = 1150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 8;      // idle clocks after the last expected word

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_payload_byte;
    logic        o_frame_fin;
    logic [3:0]  o_frame_kind;
    logic        o_frame_was_masked;
    logic [63:0] o_frame_length;
    logic        o_empty_frame;
    logic        o_last_of_frame;

    ws_tracker_pkg::ws_payload_tracker tracker = new();
    wsd_pkg::t_result                  seen_word;
    int                                in_idle_pct = 35;
    int                                out_idle_pct = 45;
    int                                bytes_sent = 0;
    int                                cycles = 0;

    websocket_frame_deframer u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_byte          (i_in_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_payload_byte     (o_payload_byte),
        .o_frame_fin        (o_frame_fin),
        .o_frame_kind       (o_frame_kind),
        .o_frame_was_masked (o_frame_was_masked),
        .o_frame_length     (o_frame_length),
        .o_empty_frame      (o_empty_frame),
        .o_last_of_frame    (o_last_of_frame)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost word ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_websocket_frame_deframer NOT OK");
            $finish;
        end
    end

    // Output side: check each accepted word, then pick the next stall.
    // Values read here are the ones present at the edge, since every
    // driver updates through nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_word.payload_byte     = o_payload_byte;
            seen_word.frame_fin        = o_frame_fin;
            seen_word.frame_kind       = o_frame_kind;
            seen_word.frame_was_masked = o_frame_was_masked;
            seen_word.frame_length     = o_frame_length;
            seen_word.empty_frame      = o_empty_frame;
            seen_word.last_of_frame    = o_last_of_frame;
            tracker.match_word(seen_word);
        end
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Send one word on the input channel. Valid is left high on return so
    // that back-to-back words never drop it; only an idle gap lowers it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do
            @(posedge i_clk);
        while (o_in_stall);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    // One frame: random first byte (reserved bits included), the length in
    // the chosen coding, a random key if masked, then n_payload random bytes.
    task automatic send_frame(input logic [63:0] plen, input t_len_code code,
                              input logic use_key, input int unsigned n_payload);
        logic [31:0] key;
        int unsigned k;
        key = $urandom;
        send_byte(8'($urandom_range(255)));
        case (code)
            LEN_SHORT: begin
                send_byte({use_key, plen[6:0]});
            end
            LEN_16: begin
                send_byte({use_key, wsd_pkg::LEN7_EXT16});
                send_byte(plen[15:8]);
                send_byte(plen[7:0]);
            end
            default: begin
                send_byte({use_key, wsd_pkg::LEN7_EXT64});
                for (k = 8; k > 0; k--)
                    send_byte(plen[8*k-1 -: 8]);
            end
        endcase
        if (use_key) begin
            for (k = 4; k > 0; k--)
                send_byte(key[8*k-1 -: 8]);
        end
        for (k = 0; k < n_payload; k++)
            send_byte(8'($urandom_range(255)));
    endtask

    // Mostly short frames; extended codings carry small lengths (coded
    // long on purpose), with zero lengths showing up now and then.
    task automatic send_random_frame();
        int unsigned plen;
        int unsigned pick;
        t_len_code   code;
        plen = ($urandom_range(99) < 8) ? $urandom_range(125) : $urandom_range(12);
        pick = $urandom_range(99);
        if (pick < 65)
            code = LEN_SHORT;
        else if (pick < 82)
            code = LEN_16;
        else
            code = LEN_64;
        send_frame(64'(plen), code, 1'($urandom_range(1)), plen);
    endtask

    logic [7:0] directed[$] = '{
        // empty unmasked frame, FIN set, text opcode
        8'h81, 8'h00,
        // reserved bits and opcode 0xF, masked, 16-bit zero length:
        // the empty marker comes on the last key byte
        8'h7F, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A,
        // 64-bit length of one, unmasked, payload byte at its maximum
        8'h89, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
        8'hFF
    };

    initial begin
        int          stage;
        logic [63:0] huge_len;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_byte(directed[i]);

        // receiver-heavy idling, then sender-heavy, then full rate
        for (stage = 0; stage < 3; stage++) begin
            case (stage)
                1: begin
                    in_idle_pct  = 45;
                    out_idle_pct = 35;
                    // one frame long enough to use the upper length byte
                    huge_len = 64'd256 + 64'($urandom_range(63));
                    send_frame(huge_len, LEN_16, 1'b1, 32'(huge_len));
                end
                2: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
                default: ;
            endcase
            while (bytes_sent < (stage + 1) * ITEMS / 3)
                send_random_frame();
        end

        // top-bit-set 64-bit length: accepted, but never finishes
        huge_len = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame(huge_len, LEN_64, 1'($urandom_range(1)), 24);
        i_in_valid <= 1'b0;

        while (tracker.due_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("tb_websocket_frame_deframer OK");
        else
            $display("tb_websocket_frame_deframer NOT OK");
        $finish;
    end

endmodule
